// ===== hw/rtl/qalu_pkg.sv =====
package qalu_pkg;

    // Opcode field width and operation codes.
    localparam int OPW = 4;

    localparam logic [OPW-1:0] OP_ADD   = 4'd0;
    localparam logic [OPW-1:0] OP_SUB   = 4'd1;
    localparam logic [OPW-1:0] OP_MUL   = 4'd2;
    localparam logic [OPW-1:0] OP_SCALE = 4'd3;
    localparam logic [OPW-1:0] OP_CONJ  = 4'd4;
    localparam logic [OPW-1:0] OP_NEG   = 4'd5;
    localparam logic [OPW-1:0] OP_ROT   = 4'd6;
    localparam logic [OPW-1:0] OP_LEN   = 4'd7;
    localparam logic [OPW-1:0] OP_NORM  = 4'd8;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic           valid;
        logic [OPW-1:0] op;
        logic           sat;
    } t_ctrl;

endpackage

// ===== hw/rtl/qalu_front.sv =====
module qalu_front #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qalu_pkg::t_ctrl      i_ctrl,
    input  logic [3:0][CW-1:0]   i_a,
    input  logic [3:0][CW-1:0]   i_b,
    input  logic [CW-1:0]        i_scale,
    output qalu_pkg::t_ctrl      o_ctrl,
    output logic [3:0][CW-1:0]   o_a,
    output logic [3:0][CW-1:0]   o_res,
    output logic [2*CW:0]        o_sumsq
);

    localparam int PW  = 2 * CW;
    localparam int MW  = 2 * CW + 3 - FB;
    localparam int RPW = MW + CW;
    localparam int XW  = 3 * CW + 6;

    localparam logic signed [XW-1:0] HI   = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] LO   = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [XW-1:0] HALF = {{(XW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    // Hamilton product terms: A index, B index and sign for each of the 16 products.
    localparam logic [1:0] MUL_IA [16] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0,
                                           2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] MUL_IB [16] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd0, 2'd2,
                                           2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic MUL_NEG [16] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    // Rotation matrix products: xx yy zz ww xy xz yz xw yw zw.
    localparam logic [1:0] ROT_IA [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                           2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] ROT_IB [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                           2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

    // Round to nearest at the fraction point, ties toward plus infinity.
    function automatic logic signed [XW-1:0] rnd(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v + HALF;
        return t >>> FB;
    endfunction

    function automatic logic ovf(input logic signed [XW-1:0] v);
        return (v > HI) || (v < LO);
    endfunction

    function automatic logic [CW-1:0] clip(input logic signed [XW-1:0] v);
        logic [CW-1:0] c;
        if (v > HI) begin
            c = HI[CW-1:0];
        end else if (v < LO) begin
            c = LO[CW-1:0];
        end else begin
            c = v[CW-1:0];
        end
        return c;
    endfunction

    // ---------------- Stage 1: simple operations and all first products ----------------
    logic signed [CW-1:0] a_s [4];
    logic signed [CW-1:0] b_s [4];
    logic signed [XW-1:0] t_add [4];
    logic signed [XW-1:0] t_sub [4];
    logic signed [XW-1:0] t_neg [4];
    logic [3:0][CW-1:0]   n1_res;
    logic                 n1_sat;
    logic signed [PW-1:0] n1_pm [16];
    logic signed [PW-1:0] n1_ps [4];
    logic signed [PW-1:0] n1_pr [10];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_s[i]   = $signed(i_a[i]);
            b_s[i]   = $signed(i_b[i]);
            t_add[i] = XW'(a_s[i]) + XW'(b_s[i]);
            t_sub[i] = XW'(a_s[i]) - XW'(b_s[i]);
            t_neg[i] = -XW'(a_s[i]);
        end
        for (int k = 0; k < 16; k++) begin
            n1_pm[k] = a_s[MUL_IA[k]] * b_s[MUL_IB[k]];
        end
        for (int k = 0; k < 4; k++) begin
            n1_ps[k] = a_s[k] * $signed(i_scale);
        end
        for (int k = 0; k < 10; k++) begin
            n1_pr[k] = a_s[ROT_IA[k]] * a_s[ROT_IB[k]];
        end
    end

    // Componentwise operations finish in the first stage.
    always_comb begin
        n1_res = '0;
        n1_sat = 1'b0;
        case (i_ctrl.op)
            qalu_pkg::OP_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    n1_res[i] = clip(t_add[i]);
                    n1_sat    = n1_sat | ovf(t_add[i]);
                end
            end
            qalu_pkg::OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    n1_res[i] = clip(t_sub[i]);
                    n1_sat    = n1_sat | ovf(t_sub[i]);
                end
            end
            qalu_pkg::OP_CONJ: begin
                for (int i = 0; i < 3; i++) begin
                    n1_res[i] = clip(t_neg[i]);
                    n1_sat    = n1_sat | ovf(t_neg[i]);
                end
                n1_res[3] = i_a[3];
            end
            qalu_pkg::OP_NEG: begin
                for (int i = 0; i < 4; i++) begin
                    n1_res[i] = clip(t_neg[i]);
                    n1_sat    = n1_sat | ovf(t_neg[i]);
                end
            end
            default: begin
                n1_res = '0;
                n1_sat = 1'b0;
            end
        endcase
    end

    qalu_pkg::t_ctrl      r1_ctrl;
    logic [3:0][CW-1:0]   r1_a;
    logic [3:0][CW-1:0]   r1_b;
    logic [3:0][CW-1:0]   r1_res;
    logic signed [PW-1:0] r1_pm [16];
    logic signed [PW-1:0] r1_ps [4];
    logic signed [PW-1:0] r1_pr [10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
        end else begin
            r1_ctrl <= {i_ctrl.valid, i_ctrl.op, n1_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a   <= i_a;
        r1_b   <= i_b;
        r1_res <= n1_res;
        r1_pm  <= n1_pm;
        r1_ps  <= n1_ps;
        r1_pr  <= n1_pr;
    end

    // ---------------- Stage 2: product sums, rounding, rotation matrix ----------------
    logic signed [XW-1:0] acc;
    logic signed [XW-1:0] v2;
    logic signed [XW-1:0] xx, yy, zz, ww, xy2, xz2, yz2, xw2, yw2, zw2;
    logic signed [XW-1:0] rm [9];
    logic signed [XW-1:0] sq;
    logic [3:0][CW-1:0]   mres;
    logic [3:0][CW-1:0]   sres;
    logic                 msat;
    logic                 ssat;
    logic signed [MW-1:0] n2_m [9];
    logic [3:0][CW-1:0]   n2_res;
    logic                 n2_sat;

    always_comb begin
        msat = 1'b0;
        ssat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int t = 0; t < 4; t++) begin
                if (MUL_NEG[r*4+t]) begin
                    acc = acc - XW'(r1_pm[r*4+t]);
                end else begin
                    acc = acc + XW'(r1_pm[r*4+t]);
                end
            end
            v2      = rnd(acc);
            mres[r] = clip(v2);
            msat    = msat | ovf(v2);
        end
        for (int i = 0; i < 4; i++) begin
            v2      = rnd(XW'(r1_ps[i]));
            sres[i] = clip(v2);
            ssat    = ssat | ovf(v2);
        end
    end

    always_comb begin
        xx  = XW'(r1_pr[0]);
        yy  = XW'(r1_pr[1]);
        zz  = XW'(r1_pr[2]);
        ww  = XW'(r1_pr[3]);
        xy2 = XW'(r1_pr[4]) <<< 1;
        xz2 = XW'(r1_pr[5]) <<< 1;
        yz2 = XW'(r1_pr[6]) <<< 1;
        xw2 = XW'(r1_pr[7]) <<< 1;
        yw2 = XW'(r1_pr[8]) <<< 1;
        zw2 = XW'(r1_pr[9]) <<< 1;
        rm[0] = (xx - zz) + (ww - yy);
        rm[1] = xy2 + zw2;
        rm[2] = xz2 - yw2;
        rm[3] = xy2 - zw2;
        rm[4] = (yy + ww) - (xx + zz);
        rm[5] = yz2 + xw2;
        rm[6] = xz2 + yw2;
        rm[7] = yz2 - xw2;
        rm[8] = (ww - yy) - (xx - zz);
        for (int k = 0; k < 9; k++) begin
            n2_m[k] = MW'(rnd(rm[k]));
        end
        sq = xx + yy + zz + ww;
    end

    always_comb begin
        case (r1_ctrl.op)
            qalu_pkg::OP_MUL: begin
                n2_res = mres;
                n2_sat = msat;
            end
            qalu_pkg::OP_SCALE: begin
                n2_res = sres;
                n2_sat = ssat;
            end
            default: begin
                n2_res = r1_res;
                n2_sat = r1_ctrl.sat;
            end
        endcase
    end

    qalu_pkg::t_ctrl      r2_ctrl;
    logic [3:0][CW-1:0]   r2_a;
    logic [3:0][CW-1:0]   r2_b;
    logic [3:0][CW-1:0]   r2_res;
    logic signed [MW-1:0] r2_m [9];
    logic [2*CW:0]        r2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctrl <= '0;
        end else begin
            r2_ctrl <= {r1_ctrl.valid, r1_ctrl.op, n2_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        r2_a   <= r1_a;
        r2_b   <= r1_b;
        r2_res <= n2_res;
        r2_m   <= n2_m;
        r2_sum <= sq[2*CW:0];
    end

    // ---------------- Stage 3: matrix entries times vector B ----------------
    logic signed [RPW-1:0] n3_rp [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n3_rp[3*i+j] = r2_m[3*i+j] * $signed(r2_b[j]);
            end
        end
    end

    qalu_pkg::t_ctrl       r3_ctrl;
    logic [3:0][CW-1:0]    r3_a;
    logic [3:0][CW-1:0]    r3_res;
    logic signed [RPW-1:0] r3_rp [9];
    logic [2*CW:0]         r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctrl <= '0;
        end else begin
            r3_ctrl <= r2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_a   <= r2_a;
        r3_res <= r2_res;
        r3_rp  <= n3_rp;
        r3_sum <= r2_sum;
    end

    // ---------------- Stage 4: rotation dot products and result select ----------------
    logic signed [XW-1:0] dot;
    logic signed [XW-1:0] v4;
    logic [3:0][CW-1:0]   rres;
    logic                 rsat;
    logic [3:0][CW-1:0]   n4_res;
    logic                 n4_sat;

    always_comb begin
        rres = '0;
        rsat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dot     = XW'(r3_rp[3*i]) + XW'(r3_rp[3*i+1]) + XW'(r3_rp[3*i+2]);
            v4      = rnd(dot);
            rres[i] = clip(v4);
            rsat    = rsat | ovf(v4);
        end
        if (r3_ctrl.op == qalu_pkg::OP_ROT) begin
            n4_res = rres;
            n4_sat = rsat;
        end else begin
            n4_res = r3_res;
            n4_sat = r3_ctrl.sat;
        end
    end

    qalu_pkg::t_ctrl    r4_ctrl;
    logic [3:0][CW-1:0] r4_a;
    logic [3:0][CW-1:0] r4_res;
    logic [2*CW:0]      r4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctrl <= '0;
        end else begin
            r4_ctrl <= {r3_ctrl.valid, r3_ctrl.op, n4_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        r4_a   <= r3_a;
        r4_res <= n4_res;
        r4_sum <= r3_sum;
    end

    assign o_ctrl  = r4_ctrl;
    assign o_a     = r4_a;
    assign o_res   = r4_res;
    assign o_sumsq = r4_sum;

endmodule

// ===== hw/rtl/qalu_sqrt.sv =====
module qalu_sqrt #(
    parameter int CW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qalu_pkg::t_ctrl    i_ctrl,
    input  logic [3:0][CW-1:0] i_a,
    input  logic [3:0][CW-1:0] i_res,
    input  logic [2*CW:0]      i_sumsq,
    output qalu_pkg::t_ctrl    o_ctrl,
    output logic [3:0][CW-1:0] o_a,
    output logic [3:0][CW-1:0] o_res,
    output logic [CW:0]        o_len
);

    localparam int RB  = CW + 1;
    localparam int RMW = RB + 3;
    localparam int RAD = 2 * RB;

    // Inputs of each digit stage; index 0 is the module input.
    logic [RMW-1:0]     w_rem  [RB+1];
    logic [RB-1:0]      w_q    [RB+1];
    logic [RAD-1:0]     w_rad  [RB+1];
    qalu_pkg::t_ctrl    w_ctrl [RB+1];
    logic [3:0][CW-1:0] w_a    [RB+1];
    logic [3:0][CW-1:0] w_res  [RB+1];

    assign w_rem[0]  = '0;
    assign w_q[0]    = '0;
    assign w_rad[0]  = RAD'(i_sumsq);
    assign w_ctrl[0] = i_ctrl;
    assign w_a[0]    = i_a;
    assign w_res[0]  = i_res;

    // One root bit per stage, two radicand bits shifted in each time.
    for (genvar k = 0; k < RB; k++) begin : g_step
        logic [RMW-1:0]     remx;
        logic [RMW-1:0]     trial;
        logic [RMW-1:0]     n_rem;
        logic [RB-1:0]      n_q;
        logic [RMW-1:0]     r_rem;
        logic [RB-1:0]      r_q;
        logic [RAD-1:0]     r_rad;
        qalu_pkg::t_ctrl    r_ctrl;
        logic [3:0][CW-1:0] r_a;
        logic [3:0][CW-1:0] r_res;

        always_comb begin
            remx  = {w_rem[k][RMW-3:0], w_rad[k][RAD-1-2*k -: 2]};
            trial = {1'b0, w_q[k], 2'b01};
            if (remx >= trial) begin
                n_rem = remx - trial;
                n_q   = {w_q[k][RB-2:0], 1'b1};
            end else begin
                n_rem = remx;
                n_q   = {w_q[k][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl <= '0;
            end else begin
                r_ctrl <= w_ctrl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_rad <= w_rad[k];
            r_a   <= w_a[k];
            r_res <= w_res[k];
        end

        assign w_rem[k+1]  = r_rem;
        assign w_q[k+1]    = r_q;
        assign w_rad[k+1]  = r_rad;
        assign w_ctrl[k+1] = r_ctrl;
        assign w_a[k+1]    = r_a;
        assign w_res[k+1]  = r_res;
    end

    // Round the floor root up when the remainder exceeds the root.
    logic [RB-1:0]      n_len;
    qalu_pkg::t_ctrl    r_ctrl;
    logic [RB-1:0]      r_len;
    logic [3:0][CW-1:0] r_a;
    logic [3:0][CW-1:0] r_res;

    assign n_len = w_q[RB] + RB'(w_rem[RB] > RMW'(w_q[RB]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= w_ctrl[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_a   <= w_a[RB];
        r_res <= w_res[RB];
    end

    assign o_ctrl = r_ctrl;
    assign o_a    = r_a;
    assign o_res  = r_res;
    assign o_len  = r_len;

endmodule

// ===== hw/rtl/qalu_div.sv =====
module qalu_div #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qalu_pkg::t_ctrl    i_ctrl,
    input  logic [3:0][CW-1:0] i_a,
    input  logic [3:0][CW-1:0] i_res,
    input  logic [CW:0]        i_len,
    output qalu_pkg::t_ctrl    o_ctrl,
    output logic [3:0][CW-1:0] o_a,
    output logic [3:0][CW-1:0] o_res,
    output logic [CW:0]        o_len,
    output logic [3:0][FB:0]   o_q
);

    localparam int RB = CW + 1;
    localparam int QB = FB + 1;
    localparam int DW = CW + FB + 1;
    localparam int RW = CW + 2;

    // Setup stage: dividend is |a| scaled up plus half the length, per lane.
    logic [CW-1:0]      mag;
    logic [3:0][DW-1:0] n0_d;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag     = i_a[i][CW-1] ? (~i_a[i] + CW'(1)) : i_a[i];
            n0_d[i] = DW'({mag, {FB{1'b0}}}) + DW'(i_len >> 1);
        end
    end

    qalu_pkg::t_ctrl    r0_ctrl;
    logic [3:0][DW-1:0] r0_d;
    logic [3:0][CW-1:0] r0_a;
    logic [3:0][CW-1:0] r0_res;
    logic [RB-1:0]      r0_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctrl <= '0;
        end else begin
            r0_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_d   <= n0_d;
        r0_a   <= i_a;
        r0_res <= i_res;
        r0_len <= i_len;
    end

    // Inputs of each quotient stage; the quotient is known to fit in QB bits.
    logic [3:0][RW-1:0] w_rem  [QB+1];
    logic [3:0][QB-1:0] w_q    [QB+1];
    logic [3:0][DW-1:0] w_d    [QB+1];
    logic [RB-1:0]      w_len  [QB+1];
    qalu_pkg::t_ctrl    w_ctrl [QB+1];
    logic [3:0][CW-1:0] w_a    [QB+1];
    logic [3:0][CW-1:0] w_res  [QB+1];

    for (genvar i = 0; i < 4; i++) begin : g_rem0
        assign w_rem[0][i] = RW'(r0_d[i][DW-1:QB]);
    end

    assign w_q[0]    = '0;
    assign w_d[0]    = r0_d;
    assign w_len[0]  = r0_len;
    assign w_ctrl[0] = r0_ctrl;
    assign w_a[0]    = r0_a;
    assign w_res[0]  = r0_res;

    // One restoring quotient bit per stage, four lanes side by side.
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [RW-1:0]      remx;
        logic [3:0][RW-1:0] n_rem;
        logic [3:0][QB-1:0] n_q;
        logic [3:0][RW-1:0] r_rem;
        logic [3:0][QB-1:0] r_q;
        logic [3:0][DW-1:0] r_d;
        logic [RB-1:0]      r_len;
        qalu_pkg::t_ctrl    r_ctrl;
        logic [3:0][CW-1:0] r_a;
        logic [3:0][CW-1:0] r_res;

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                remx = {w_rem[k][i][RW-2:0], w_d[k][i][QB-1-k]};
                if (remx >= RW'(w_len[k])) begin
                    n_rem[i] = remx - RW'(w_len[k]);
                    n_q[i]   = {w_q[k][i][QB-2:0], 1'b1};
                end else begin
                    n_rem[i] = remx;
                    n_q[i]   = {w_q[k][i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl <= '0;
            end else begin
                r_ctrl <= w_ctrl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_d   <= w_d[k];
            r_len <= w_len[k];
            r_a   <= w_a[k];
            r_res <= w_res[k];
        end

        assign w_rem[k+1]  = r_rem;
        assign w_q[k+1]    = r_q;
        assign w_d[k+1]    = r_d;
        assign w_len[k+1]  = r_len;
        assign w_ctrl[k+1] = r_ctrl;
        assign w_a[k+1]    = r_a;
        assign w_res[k+1]  = r_res;
    end

    assign o_ctrl = w_ctrl[QB];
    assign o_a    = w_a[QB];
    assign o_res  = w_res[QB];
    assign o_len  = w_len[QB];
    assign o_q    = w_q[QB];

endmodule

// ===== hw/rtl/quaternion_alu.sv =====
// Quaternion arithmetic unit, fully pipelined.
// Every item passes through the front pipeline, the bit-per-stage square root and quotient
// pipelines, and a registered final select on its way from start to o_valid.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits; items in flight are dropped.
module quaternion_alu #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [qalu_pkg::OPW-1:0]   i_opcode,
    input  logic [COMPONENT_WIDTH-1:0] i_a_x,
    input  logic [COMPONENT_WIDTH-1:0] i_a_y,
    input  logic [COMPONENT_WIDTH-1:0] i_a_z,
    input  logic [COMPONENT_WIDTH-1:0] i_a_w,
    input  logic [COMPONENT_WIDTH-1:0] i_b_x,
    input  logic [COMPONENT_WIDTH-1:0] i_b_y,
    input  logic [COMPONENT_WIDTH-1:0] i_b_z,
    input  logic [COMPONENT_WIDTH-1:0] i_b_w,
    input  logic [COMPONENT_WIDTH-1:0] i_scale_factor,
    output logic                       o_valid,
    output logic [COMPONENT_WIDTH-1:0] o_res_x,
    output logic [COMPONENT_WIDTH-1:0] o_res_y,
    output logic [COMPONENT_WIDTH-1:0] o_res_z,
    output logic [COMPONENT_WIDTH-1:0] o_res_w,
    output logic [COMPONENT_WIDTH-1:0] o_magnitude,
    output logic                       o_saturated,
    output logic                       o_zero_length
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int RB = CW + 1;
    localparam int QB = FB + 1;
    localparam int EW = ((QB > CW) ? QB : CW) + 1;

    localparam logic [EW-1:0] QHI   = EW'({(CW-1){1'b1}});
    localparam logic [RB-1:0] LENHI = RB'({CW{1'b1}});

    // The pipeline never holds off an item.
    assign busy = 1'b0;

    qalu_pkg::t_ctrl    n_in;
    logic [3:0][CW-1:0] in_a;
    logic [3:0][CW-1:0] in_b;

    always_comb begin
        n_in.valid = start;
        n_in.op    = i_opcode;
        n_in.sat   = 1'b0;
    end

    assign in_a = {i_a_w, i_a_z, i_a_y, i_a_x};
    assign in_b = {i_b_w, i_b_z, i_b_y, i_b_x};

    qalu_pkg::t_ctrl    f_ctrl;
    logic [3:0][CW-1:0] f_a;
    logic [3:0][CW-1:0] f_res;
    logic [2*CW:0]      f_sum;

    qalu_front #(.CW(CW), .FB(FB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (n_in),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_scale (i_scale_factor),
        .o_ctrl  (f_ctrl),
        .o_a     (f_a),
        .o_res   (f_res),
        .o_sumsq (f_sum)
    );

    qalu_pkg::t_ctrl    s_ctrl;
    logic [3:0][CW-1:0] s_a;
    logic [3:0][CW-1:0] s_res;
    logic [RB-1:0]      s_len;

    qalu_sqrt #(.CW(CW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (f_ctrl),
        .i_a     (f_a),
        .i_res   (f_res),
        .i_sumsq (f_sum),
        .o_ctrl  (s_ctrl),
        .o_a     (s_a),
        .o_res   (s_res),
        .o_len   (s_len)
    );

    qalu_pkg::t_ctrl    d_ctrl;
    logic [3:0][CW-1:0] d_a;
    logic [3:0][CW-1:0] d_res;
    logic [RB-1:0]      d_len;
    logic [3:0][QB-1:0] d_q;

    qalu_div #(.CW(CW), .FB(FB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s_ctrl),
        .i_a     (s_a),
        .i_res   (s_res),
        .i_len   (s_len),
        .o_ctrl  (d_ctrl),
        .o_a     (d_a),
        .o_res   (d_res),
        .o_len   (d_len),
        .o_q     (d_q)
    );

    // Final select: length, normalize, or the result formed up front.
    logic [3:0][CW-1:0] n_res;
    logic [CW-1:0]      n_mag;
    logic               n_sat;
    logic               n_zl;
    logic [EW-1:0]      qe;
    logic [EW-1:0]      qn;

    always_comb begin
        n_res = '0;
        n_mag = '0;
        n_sat = 1'b0;
        n_zl  = 1'b0;
        qe    = '0;
        qn    = '0;
        case (d_ctrl.op)
            qalu_pkg::OP_LEN: begin
                if (d_len > LENHI) begin
                    n_mag = '1;
                    n_sat = 1'b1;
                end else begin
                    n_mag = d_len[CW-1:0];
                end
            end
            qalu_pkg::OP_NORM: begin
                if (d_len == '0) begin
                    n_res = d_a;
                    n_zl  = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        qe = EW'(d_q[i]);
                        qn = -qe;
                        if (d_a[i][CW-1]) begin
                            if (qe > QHI + EW'(1)) begin
                                n_res[i] = {1'b1, {(CW-1){1'b0}}};
                                n_sat    = 1'b1;
                            end else begin
                                n_res[i] = qn[CW-1:0];
                            end
                        end else begin
                            if (qe > QHI) begin
                                n_res[i] = {1'b0, {(CW-1){1'b1}}};
                                n_sat    = 1'b1;
                            end else begin
                                n_res[i] = qe[CW-1:0];
                            end
                        end
                    end
                end
            end
            default: begin
                n_res = d_res;
                n_sat = d_ctrl.sat;
            end
        endcase
    end

    logic               r_valid;
    logic [3:0][CW-1:0] r_res;
    logic [CW-1:0]      r_mag;
    logic               r_sat;
    logic               r_zl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_mag <= n_mag;
        r_sat <= n_sat;
        r_zl  <= n_zl;
    end

    assign o_valid       = r_valid;
    assign o_res_x       = r_res[0];
    assign o_res_y       = r_res[1];
    assign o_res_z       = r_res[2];
    assign o_res_w       = r_res[3];
    assign o_magnitude   = r_mag;
    assign o_saturated   = r_sat;
    assign o_zero_length = r_zl;

endmodule
